/* hw/rtl/tnd_pkg.sv */
// ----------------------------------------------------------------------------
// tnd_pkg: shared types and constants for tensor node DOF ordering
// Field widths, register indexes and the beat and configuration structs.
// ----------------------------------------------------------------------------
package tnd_pkg;

  localparam int CoordW   = 4;
  localparam int DimsW    = 2;
  localparam int OrderW   = 4;
  localparam int DofW     = 12;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;
  localparam int CoefW    = 5;
  localparam int SqW      = 2 * OrderW;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgIdxDimensions   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxElementOrder = 1'b1;

  // Reset values
  localparam logic [DimsW-1:0]  DimsReset  = 2'd3;
  localparam logic [OrderW-1:0] OrderReset = 4'd1;

  // Element kinds by dimension
  localparam logic [DimsW-1:0] DimsLine = 2'd1;
  localparam logic [DimsW-1:0] DimsQuad = 2'd2;

  // Input beat: one tensor node position
  typedef struct packed {
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [CoordW-1:0] coord_z;
  } tnd_in_t;

  // Result beat: DOF number and reject flag
  typedef struct packed {
    logic [DofW-1:0] dof_number;
    logic            out_of_range;
  } tnd_out_t;

  // Configuration with quantities derived from the order
  typedef struct packed {
    logic [DimsW-1:0]  dims;
    logic [OrderW-1:0] order;
    logic [OrderW-1:0] m;         // nodes per edge, order - 1
    logic [SqW-1:0]    mm;        // nodes per face
    logic [DofW-1:0]   face_base; // first face DOF of a hexahedron
    logic              ok;        // dimensions and order usable
  } tnd_cfg_t;

endpackage

/* hw/rtl/tnd_if.sv */
// ----------------------------------------------------------------------------
// tnd_if: valid/ready stream channels
// Input channel carries node positions, output channel carries DOF results.
// ----------------------------------------------------------------------------
interface tnd_in_if import tnd_pkg::*; ();
  logic    valid;
  logic    ready;
  tnd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tnd_out_if import tnd_pkg::*; ();
  logic     valid;
  logic     ready;
  tnd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tnd_cfg.sv */
// ----------------------------------------------------------------------------
// tnd_cfg: configuration registers
// Holds dimensions and order and registers the per-order constants with them.
// ----------------------------------------------------------------------------
module tnd_cfg import tnd_pkg::*; #(
  parameter int MAX_ORDER = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output tnd_cfg_t            cfg_o
);

  tnd_cfg_t          cfg_d, cfg_q;
  logic [DimsW-1:0]  dims_d;
  logic [OrderW-1:0] order_d;
  logic [OrderW-1:0] m_d;

  // Pick up a write, then derive the order constants from the new values
  always_comb begin
    dims_d  = cfg_q.dims;
    order_d = cfg_q.order;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxDimensions:   dims_d  = cfg_data_i[DimsW-1:0];
        CfgIdxElementOrder: order_d = cfg_data_i[OrderW-1:0];
        default: ;
      endcase
    end
    m_d             = order_d - OrderW'(1);
    cfg_d.dims      = dims_d;
    cfg_d.order     = order_d;
    cfg_d.m         = m_d;
    cfg_d.mm        = SqW'(m_d) * SqW'(m_d);
    cfg_d.face_base = DofW'(8) + DofW'(m_d) * DofW'(12);
    cfg_d.ok        = (dims_d != '0) && (order_d != '0) && (int'(order_d) <= MAX_ORDER);
  end

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dims      <= DimsReset;
      cfg_q.order     <= OrderReset;
      cfg_q.m         <= '0;
      cfg_q.mm        <= '0;
      cfg_q.face_base <= DofW'(8);
      cfg_q.ok        <= (int'(OrderReset) <= MAX_ORDER);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/tnd_map.sv */
// ----------------------------------------------------------------------------
// tnd_map: node position to DOF number
// Classifies each axis, picks base and coefficients, then multiplies and adds.
// ----------------------------------------------------------------------------
module tnd_map import tnd_pkg::*; (
  input  tnd_cfg_t cfg_i,
  input  tnd_in_t  node_i,
  output tnd_out_t res_o
);

  logic [CoordW-1:0]   x, y, z, o;
  logic                x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  logic                bx, by, bz;
  logic                bad;
  logic [1:0]          crn;
  logic [DofW-1:0]     base;
  logic [CoefW-1:0]    coef_a, coef_b;
  logic [CoordW-1:0]   offs;
  logic [DofW-1:0]     prod_a;
  logic [CoefW+OrderW-1:0] prod_b;
  logic [DofW-1:0]     sum;

  assign x = node_i.coord_x;
  assign y = node_i.coord_y;
  assign z = node_i.coord_z;
  assign o = cfg_i.order;

  // Axis classes: low end, high end, otherwise interior
  assign x_lo = (x == '0);
  assign x_hi = (x == o);
  assign y_lo = (y == '0);
  assign y_hi = (y == o);
  assign z_lo = (z == '0);
  assign z_hi = (z == o);
  assign bx   = x_lo | x_hi;
  assign by   = y_lo | y_hi;
  assign bz   = z_lo | z_hi;

  // Vertex number inside a square layer
  assign crn = y_hi ? (x_hi ? 2'd2 : 2'd3) : (x_hi ? 2'd1 : 2'd0);

  // Reject bad configuration, coordinates past the order, stray unused axes
  always_comb begin
    bad = !cfg_i.ok || (x > o);
    if (cfg_i.dims >= DimsQuad) bad = bad || (y > o);
    else                        bad = bad || (y != '0);
    if (cfg_i.dims > DimsQuad)  bad = bad || (z > o);
    else                        bad = bad || (z != '0);
  end

  // Select base, face coefficient, edge coefficient and offset
  always_comb begin
    base   = '0;
    coef_a = '0;
    coef_b = '0;
    offs   = '0;
    case (cfg_i.dims)
      DimsLine: begin
        if (x_lo)      base = '0;
        else if (x_hi) base = DofW'(1);
        else           base = DofW'(x) + DofW'(1);
      end
      DimsQuad: begin
        base = DofW'(4);
        if (bx && by) begin
          base = DofW'(crn);
        end else if (!bx && y_lo) begin
          offs = x - 4'd1;
        end else if (x_hi && !by) begin
          coef_b = CoefW'(1);
          offs   = y - 4'd1;
        end else if (!bx && y_hi) begin
          coef_b = CoefW'(2);
          offs   = o - x - 4'd1;
        end else if (x_lo && !by) begin
          coef_b = CoefW'(3);
          offs   = o - y - 4'd1;
        end else begin
          coef_b = CoefW'(y) + CoefW'(3);
          offs   = x - 4'd1;
        end
      end
      default: begin
        if (bx && by && bz) begin
          base = DofW'({z_hi, 2'b00}) + DofW'(crn);
        end else if (bz && (bx != by)) begin
          // Edge in a z layer
          base = DofW'(8);
          if (!bx) begin
            coef_b = CoefW'({z_hi, y_hi, 1'b0});
            offs   = x - 4'd1;
          end else begin
            coef_b = CoefW'({z_hi, 2'b00}) + (x_hi ? CoefW'(1) : CoefW'(3));
            offs   = y - 4'd1;
          end
        end else if (bx && by) begin
          // Edge along z
          base   = DofW'(8);
          coef_b = CoefW'(8) + CoefW'(crn);
          offs   = z - 4'd1;
        end else begin
          base = cfg_i.face_base;
          if (bz) begin
            if (z_lo) begin
              coef_b = CoefW'(o - y - 4'd1);
            end else begin
              coef_a = CoefW'(5);
              coef_b = CoefW'(y - 4'd1);
            end
            offs = x - 4'd1;
          end else if (by) begin
            if (y_lo) begin
              coef_a = CoefW'(1);
              coef_b = CoefW'(x - 4'd1);
              offs   = z - 4'd1;
            end else begin
              coef_a = CoefW'(3);
              coef_b = CoefW'(z - 4'd1);
              offs   = o - x - 4'd1;
            end
          end else if (bx) begin
            coef_b = CoefW'(z - 4'd1);
            if (x_hi) begin
              coef_a = CoefW'(2);
              offs   = y - 4'd1;
            end else begin
              coef_a = CoefW'(4);
              offs   = o - y - 4'd1;
            end
          end else begin
            // Interior, after the six faces
            coef_a = CoefW'(z) + CoefW'(5);
            coef_b = CoefW'(y - 4'd1);
            offs   = x - 4'd1;
          end
        end
      end
    endcase
  end

  // Combine: base + a*mm + b*m + offset, wrapped to the DOF width
  assign prod_a = DofW'(coef_a) * DofW'(cfg_i.mm);
  assign prod_b = (CoefW+OrderW)'(coef_b) * (CoefW+OrderW)'(cfg_i.m);
  assign sum    = base + prod_a + DofW'(prod_b) + DofW'(offs);

  assign res_o.dof_number   = bad ? '0 : sum;
  assign res_o.out_of_range = bad;

endmodule

/* hw/rtl/tnd_pipe.sv */
// ----------------------------------------------------------------------------
// tnd_pipe: input register, mapping logic and result register
// Two valid/ready stages; each moves whenever the stage after it has room.
// ----------------------------------------------------------------------------
module tnd_pipe import tnd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tnd_cfg_t cfg_i,
  tnd_in_if.sink   in_i,
  tnd_out_if.source out_o
);

  logic     s1_valid_q, s1_valid_d;
  logic     s2_valid_q, s2_valid_d;
  logic     s1_ready, s2_ready;
  tnd_in_t  s1_data_q;
  tnd_out_t s2_data_q;
  tnd_out_t map_res;

  // Ready chain: a stage takes a beat when it is empty or drains this cycle
  assign s2_ready   = !s2_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  assign s1_valid_d = s1_ready ? in_i.valid : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  tnd_map u_map (
    .cfg_i  (cfg_i),
    .node_i (s1_data_q),
    .res_o  (map_res)
  );

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Load payloads on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_ready) begin
      s1_data_q <= in_i.data;
    end
    if (s1_valid_q && s2_ready) begin
      s2_data_q <= map_res;
    end
  end

  assign out_o.valid = s2_valid_q;
  assign out_o.data  = s2_data_q;

endmodule

/* hw/rtl/tensor_node_dof_ordering.sv */
// ----------------------------------------------------------------------------
// tensor_node_dof_ordering: tensor node to DOF number for line, quad, hex
// Top level: configuration registers and the two-stage mapping pipeline.
// ----------------------------------------------------------------------------
// The block returns each node's DOF number, in order vertices, edges, faces,
// interior, from its result register. Throughput is one beat per clock, set
// by the input and result registers, which both advance every cycle the output
// is taken; a stalled output holds one result and one node, then drops input
// ready. Registers are to be written only while the pipeline is empty, which
// the block does not enforce; they apply to every later beat. A coordinate
// above the order, a nonzero unused axis, dimensions 0 or an order of 0 or
// above MAX_ORDER returns out_of_range with DOF number 0.
module tensor_node_dof_ordering import tnd_pkg::*; #(
  parameter int MAX_ORDER = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  tnd_in_if.sink              in_i,
  tnd_out_if.source           out_o
);

  tnd_cfg_t cfg;

  tnd_cfg #(
    .MAX_ORDER (MAX_ORDER)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tnd_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

`ifndef SYNTH
  // An empty result stage always lets a new beat in
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty result stage");

  // After an accepted beat, the output shows a valid result beat
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> ##1 out_o.valid)
    else $error("accepted beat did not reach the output");

  // A rejected node carries DOF number zero
  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.out_of_range) |-> (out_o.data.dof_number == '0))
    else $error("rejected node with nonzero DOF number");
`endif

endmodule

/* tb/tb_tensor_node_dof_ordering.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tensor_node_dof_ordering: self-checking bench for node to DOF ordering
// Drives node positions through line, quad and hex settings, computes each
// DOF number and reject flag on the side and compares every result beat in
// order, under random sender gaps, receiver stalls and one long back-pressure.
// ----------------------------------------------------------------------------
module tb_tensor_node_dof_ordering;
  import tnd_pkg::*;

  localparam int MaxOrder      = 15;
  localparam int LongHold      = 64;
  localparam int WatchdogLimit = 2000;

  localparam logic [DimsW-1:0] DimsNone = 2'd0;
  localparam logic [DimsW-1:0] DimsHex  = 2'd3;

  // Idling modes of the two sides
  typedef enum int {IdleSendLight, IdleSendHeavy, IdleNone} idle_mode_e;

  // Position of one coordinate along its axis
  typedef enum logic [1:0] {AxLow, AxHigh, AxMid} axis_pos_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tnd_in_if  in_if ();
  tnd_out_if out_if ();

  // Mirror of the configuration registers
  logic [DimsW-1:0]  cur_dims;
  logic [OrderW-1:0] cur_order;

  tnd_in_t    node_pending[$];
  tnd_out_t   dof_due[$];
  logic       node_taken;
  idle_mode_e idle_mode;
  int         send_gap_pct;
  int         recv_gap_pct;
  int         setting_no;
  bit         squeeze_setting;
  int         squeezed_setting;
  int         hold_left;
  int         stall_cycles;
  int         errors;
  int         nodes_sent;
  int         dofs_seen;
  int         rejects_seen;

  tensor_node_dof_ordering #(
    .MAX_ORDER (MaxOrder)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic axis_pos_e axis_pos(int c, int o);
    if (c == 0) return AxLow;
    if (c == o) return AxHigh;
    return AxMid;
  endfunction

  // Vertex within a square layer, counterclockwise from the origin
  function automatic int sq_corner(axis_pos_e ax, axis_pos_e ay);
    if (ay == AxHigh) return (ax == AxHigh) ? 2 : 3;
    return (ax == AxHigh) ? 1 : 0;
  endfunction

  // Expected DOF number and reject flag of one node under the current setting
  function automatic tnd_out_t node_dof(tnd_in_t node);
    int        x, y, z, o, d, m, mm, fb, base, dof;
    axis_pos_e ax, ay, az;
    bit        bx, by, bz, bad;
    tnd_out_t  res;
    x   = node.coord_x;
    y   = node.coord_y;
    z   = node.coord_z;
    o   = cur_order;
    d   = cur_dims;
    dof = 0;
    bad = (d == 0) || (o == 0) || (o > MaxOrder);
    if (x > o) bad = 1'b1;
    if ((d >= 2) ? (y > o) : (y != 0)) bad = 1'b1;
    if ((d >= 3) ? (z > o) : (z != 0)) bad = 1'b1;
    if (!bad) begin
      m  = o - 1;
      mm = m * m;
      fb = 8 + 12 * m;
      ax = axis_pos(x, o);
      ay = axis_pos(y, o);
      az = axis_pos(z, o);
      bx = (ax != AxMid);
      by = (ay != AxMid);
      bz = (az != AxMid);
      if (d == DimsLine) begin
        dof = (ax == AxLow) ? 0 : (ax == AxHigh) ? 1 : x + 1;
      end else if (d == DimsQuad) begin
        if (bx && by) dof = sq_corner(ax, ay);
        else if (ax == AxMid && ay == AxLow) dof = 4 + x - 1;
        else if (ax == AxHigh && ay == AxMid) dof = 4 + m + y - 1;
        else if (ax == AxMid && ay == AxHigh) dof = 4 + 2 * m + o - x - 1;
        else if (ax == AxLow && ay == AxMid) dof = 4 + 3 * m + o - y - 1;
        else dof = 4 + 4 * m + (y - 1) * m + x - 1;
      end else begin
        if (bx && by && bz) begin
          dof = ((az == AxHigh) ? 4 : 0) + sq_corner(ax, ay);
        end else if (bz && (bx != by)) begin
          // edges in the bottom and top layers
          base = 8 + ((az == AxHigh) ? 4 * m : 0);
          if (!bx) dof = base + ((ay == AxHigh) ? 2 * m : 0) + x - 1;
          else dof = base + ((ax == AxHigh) ? m : 3 * m) + y - 1;
        end else if (bx && by) begin
          dof = 8 + (8 + sq_corner(ax, ay)) * m + z - 1;
        end else if (bz) begin
          if (az == AxLow) dof = fb + (o - y - 1) * m + x - 1;
          else dof = fb + 5 * mm + (y - 1) * m + x - 1;
        end else if (by) begin
          if (ay == AxLow) dof = fb + mm + (x - 1) * m + z - 1;
          else dof = fb + 3 * mm + (z - 1) * m + o - x - 1;
        end else if (bx) begin
          if (ax == AxHigh) dof = fb + 2 * mm + (z - 1) * m + y - 1;
          else dof = fb + 4 * mm + (z - 1) * m + o - y - 1;
        end else begin
          dof = fb + 6 * mm + (z - 1) * mm + (y - 1) * m + x - 1;
        end
      end
    end
    res.dof_number   = dof[DofW-1:0];
    res.out_of_range = bad;
    return res;
  endfunction

  // Pick one coordinate, leaning on both ends of the axis
  function automatic logic [CoordW-1:0] pick_coord();
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return '0;
    if (sel == 1) return cur_order;
    return CoordW'($urandom_range(cur_order));
  endfunction

  // Mostly legal nodes of the active element, some fully random noise
  function automatic tnd_in_t rand_node();
    tnd_in_t node;
    int      act;
    act = (cur_dims == DimsNone) ? 3 : cur_dims;
    if ($urandom_range(99) < 12) begin
      node.coord_x = CoordW'($urandom_range(15));
      node.coord_y = CoordW'($urandom_range(15));
      node.coord_z = CoordW'($urandom_range(15));
    end else begin
      node.coord_x = pick_coord();
      node.coord_y = (act >= 2) ? pick_coord() : '0;
      node.coord_z = (act >= 3) ? pick_coord() : '0;
    end
    return node;
  endfunction

  task automatic push_node(input int x, input int y, input int z);
    tnd_in_t node;
    node.coord_x = CoordW'(x);
    node.coord_y = CoordW'(y);
    node.coord_z = CoordW'(z);
    node_pending.push_back(node);
  endtask

  // Hold until every queued node has been sent and answered
  task automatic drain();
    while (node_pending.size() != 0 || dof_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == CfgIdxDimensions) cur_dims = val[DimsW-1:0];
    else cur_order = val[OrderW-1:0];
  endtask

  task automatic set_element(input logic [DimsW-1:0] d, input int o, input idle_mode_e md);
    drain();
    write_reg(CfgIdxDimensions, CfgDataW'(d));
    write_reg(CfgIdxElementOrder, CfgDataW'(o));
    idle_mode    = md;
    send_gap_pct = (md == IdleSendLight) ? 24 : (md == IdleSendHeavy) ? 78 : 0;
    recv_gap_pct = (md == IdleSendLight) ? 78 : (md == IdleSendHeavy) ? 24 : 0;
    setting_no++;
  endtask

  task automatic random_nodes(input logic [DimsW-1:0] d, input int o, input idle_mode_e md,
                              input bit squeeze, input int count);
    set_element(d, o, md);
    squeeze_setting = squeeze;
    repeat (count) node_pending.push_back(rand_node());
  endtask

  // Offer node beats on the falling edge, hold a beat until it is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || node_taken === 1'b1) begin
      if (node_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_if.valid <= 1'b1;
        in_if.data  <= node_pending[0];
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Retire accepted node beats and queue their DOF numbers
  always @(posedge clk_i) begin
    node_taken <= in_if.valid & in_if.ready;
    if (in_if.valid && in_if.ready) begin
      dof_due.push_back(node_dof(in_if.data));
      void'(node_pending.pop_front());
      nodes_sent++;
    end
  end

  // Stall the result side, with one long hold-off in the squeeze setting
  always @(negedge clk_i) begin
    if (squeeze_setting && squeezed_setting != setting_no) begin
      squeezed_setting = setting_no;
      hold_left        = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Check each result beat against the oldest pending DOF number
  always @(posedge clk_i) begin
    tnd_out_t want;
    if (out_if.valid && out_if.ready) begin
      dofs_seen++;
      if (dof_due.size() == 0) begin
        $error("unexpected result beat: dof_number %0d out_of_range %0d",
               out_if.data.dof_number, out_if.data.out_of_range);
        errors++;
      end else begin
        want = dof_due.pop_front();
        if (want.out_of_range) rejects_seen++;
        if (out_if.data.dof_number !== want.dof_number) begin
          $error("dof_number: expected %0d, got %0d", want.dof_number,
                 out_if.data.dof_number);
          errors++;
        end
        if (out_if.data.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                 out_if.data.out_of_range);
          errors++;
        end
      end
    end
  end

  // Abort when neither side moves a beat for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("tb_tensor_node_dof_ordering: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgIdxDimensions;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.data       = '0;
    out_if.ready     = 1'b0;
    node_taken       = 1'b0;
    cur_dims         = DimsReset;
    cur_order        = OrderReset;
    idle_mode        = IdleNone;
    send_gap_pct     = 0;
    recv_gap_pct     = 0;
    setting_no       = 0;
    squeeze_setting  = 1'b0;
    squeezed_setting = -1;
    hold_left        = 0;
    stall_cycles     = 0;
    errors           = 0;
    nodes_sent       = 0;
    dofs_seen        = 0;
    rejects_seen     = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: linear hex, plus a coordinate past the order
    push_node(0, 0, 0);
    push_node(1, 1, 1);
    push_node(2, 0, 0);

    // cubic hex: one node of every vertex, edge, face and interior class, plus nodes past the order
    set_element(DimsHex, 3, IdleNone);
    push_node(3, 3, 3);
    push_node(1, 0, 0);
    push_node(3, 2, 3);
    push_node(3, 3, 1);
    push_node(1, 2, 0);
    push_node(2, 0, 1);
    push_node(3, 1, 2);
    push_node(1, 3, 2);
    push_node(0, 2, 1);
    push_node(2, 1, 3);
    push_node(2, 2, 1);
    push_node(4, 0, 0);
    push_node(0, 15, 0);
    push_node(15, 15, 15);

    // top order quad and line, nonzero unused axes
    set_element(DimsQuad, 15, IdleNone);
    push_node(15, 15, 0);
    push_node(7, 0, 0);
    push_node(0, 15, 3);
    set_element(DimsLine, 15, IdleNone);
    push_node(15, 0, 0);
    push_node(3, 0, 0);
    push_node(0, 1, 0);

    // unusable settings: dimensions zero, order zero
    set_element(DimsNone, 4, IdleNone);
    push_node(0, 0, 0);
    set_element(DimsHex, 0, IdleNone);
    push_node(0, 0, 0);

    // random nodes: light sender gaps and heavy receiver stalls first
    random_nodes(DimsHex, 15, IdleSendLight, 1'b0, 80);
    random_nodes(DimsQuad, 7, IdleSendLight, 1'b0, 60);
    random_nodes(DimsLine, 1, IdleSendLight, 1'b0, 30);
    random_nodes(DimsHex, $urandom_range(15, 1), IdleSendLight, 1'b0, 60);
    // then the other way round
    random_nodes(DimsHex, 2, IdleSendHeavy, 1'b0, 60);
    random_nodes(DimsQuad, 15, IdleSendHeavy, 1'b0, 50);
    random_nodes(DimsNone, 5, IdleSendHeavy, 1'b0, 20);
    random_nodes(DimsHex, 0, IdleSendHeavy, 1'b0, 20);
    // then full rate, filling the pipeline behind a long output stall once
    random_nodes(DimsHex, 4, IdleNone, 1'b1, 80);
    random_nodes(DimsLine, 15, IdleNone, 1'b0, 40);
    random_nodes(DimsHex, 1, IdleNone, 1'b0, 40);

    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d node beats over %0d element settings, %0d results, %0d rejected",
             nodes_sent, setting_no + 1, dofs_seen, rejects_seen);
    $display("line/quad/hex at orders 0..15, both idling splits, full rate and one long stall");
    if (errors == 0) begin
      $display("tb_tensor_node_dof_ordering: PASS");
    end else begin
      $display("tb_tensor_node_dof_ordering: FAIL");
    end
    $finish;
  end

endmodule
